// ----- rtl/ard_pkg.sv -----
// Shared types, constants and character helpers for the authority record decoder.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package ard_pkg;

	// Record layout offsets.
	localparam logic [7:0] IDENT_START = 8'd8;
	localparam logic [7:0] IDENT_END   = 8'd24;
	localparam logic [7:0] SETTING_END = 8'd32;
	localparam logic [7:0] LAYOUT_END  = 8'd40;
	localparam logic [7:0] POS_MAX     = 8'd255;

	// Result kinds.
	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes.
	localparam logic [1:0] VERDICT_OK     = 2'd0;
	localparam logic [1:0] VERDICT_LENGTH = 2'd1;
	localparam logic [1:0] VERDICT_MAGIC  = 2'd2;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One queued job: the results caused by a single input byte.
	typedef struct packed {
		logic [1:0]      n_chars;
		logic [1:0][5:0] char_idx;
		logic            has_verdict;
		logic [1:0]      verdict;
		logic [63:0]     cfg;
		logic [63:0]     topo;
	} job_t;

	// Expected magic byte for header offsets 0 to 7.
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] m;
		unique case (idx)
			3'd0: m = 8'h4c; // 'L'
			3'd1: m = 8'h57; // 'W'
			3'd2: m = 8'h44; // 'D'
			3'd3: m = 8'h41; // 'A'
			3'd4: m = 8'h31; // '1'
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// Maps a 6-bit value to its base64url ASCII character.
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'h61 + {1'b0, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 7'h30 + {1'b0, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 7'h2d;
		end else begin
			c = 7'h5f;
		end
		return c;
	endfunction

endpackage

// ----- rtl/ard_front.sv -----
// Front part: takes record bytes, tracks magic, base64 bits and the two words,
// and turns each byte with results into a job for the queue. Depends on ard_pkg.
`timescale 1ns / 1ps

module ard_front
	import ard_pkg::*;
#(
	parameter int RECORD_BYTES = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       take,
	output logic       push,
	output job_t       push_job
);

	logic [7:0]  pos_q;
	logic        magic_q;
	logic [12:0] pend_q;
	logic [3:0]  pcnt_q;
	logic [63:0] set_q;
	logic [63:0] lay_q;

	logic        in_magic, in_ident, in_set, in_lay;
	logic [12:0] pb1, pb_rem;
	logic [3:0]  cnt1, cnt2, cnt3;
	logic        emit0, emit1, flush;
	logic [5:0]  c0, c1, cf;
	logic        magic_nxt;
	logic [63:0] set_nxt, lay_nxt;
	logic [12:0] pend_nxt;
	logic [3:0]  pcnt_nxt;
	logic [7:0]  pos_nxt;
	logic [1:0]  nc;

	// Section decode by byte position.
	assign in_magic = (pos_q < IDENT_START);
	assign in_ident = !in_magic && (pos_q < IDENT_END);
	assign in_set   = (pos_q >= IDENT_END) && (pos_q < SETTING_END);
	assign in_lay   = (pos_q >= SETTING_END) && (pos_q < LAYOUT_END);

	// Base64 slicing: at most two full characters per byte, then an optional flush.
	always_comb begin
		pb1    = {pend_q[4:0], data_byte};
		cnt1   = pcnt_q + 4'd8;
		emit0  = (cnt1 >= 4'd6);
		cnt2   = emit0 ? cnt1 - 4'd6 : cnt1;
		c0     = 6'(pb1 >> cnt2);
		emit1  = emit0 && (cnt2 >= 4'd6);
		cnt3   = emit1 ? cnt2 - 4'd6 : cnt2;
		c1     = 6'(pb1 >> cnt3);
		pb_rem = pb1 & ((13'd1 << cnt3) - 13'd1);
		flush  = (pos_q == IDENT_END - 8'd1) && (cnt3 != 4'd0);
		cf     = 6'(pb_rem << (4'd6 - cnt3));
	end

	// Next state of the trackers.
	always_comb begin
		magic_nxt = magic_q;
		pend_nxt  = pend_q;
		pcnt_nxt  = pcnt_q;
		set_nxt   = set_q;
		lay_nxt   = lay_q;
		if (in_magic) begin
			if (data_byte != magic_byte(pos_q[2:0])) begin
				magic_nxt = 1'b0;
			end
		end else if (in_ident) begin
			pend_nxt = flush ? 13'd0 : pb_rem;
			pcnt_nxt = flush ? 4'd0 : cnt3;
		end else if (in_set) begin
			set_nxt = {set_q[55:0], data_byte};
		end else if (in_lay) begin
			lay_nxt = {lay_q[55:0], data_byte};
		end
		pos_nxt = (pos_q != POS_MAX) ? pos_q + 8'd1 : pos_q;
	end

	// Build the job for this byte.
	always_comb begin
		nc = 2'd0;
		if (in_ident && magic_q) begin
			nc = 2'({1'b0, emit0} + {1'b0, emit1} + {1'b0, flush});
		end
		push_job             = '0;
		push_job.n_chars     = nc;
		push_job.char_idx[0] = emit0 ? c0 : cf;
		push_job.char_idx[1] = emit1 ? c1 : cf;
		push_job.has_verdict = final_byte;
		if (pos_nxt != 8'(RECORD_BYTES)) begin
			push_job.verdict = VERDICT_LENGTH;
		end else if (!magic_nxt) begin
			push_job.verdict = VERDICT_MAGIC;
		end else begin
			push_job.verdict = VERDICT_OK;
			push_job.cfg     = set_nxt;
			push_job.topo    = lay_nxt;
		end
	end

	assign push = take && ((nc != 2'd0) || final_byte);

	// Tracker registers; a final byte returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			magic_q <= 1'b1;
			pend_q  <= '0;
			pcnt_q  <= '0;
			set_q   <= '0;
			lay_q   <= '0;
		end else if (take) begin
			if (final_byte) begin
				pos_q   <= '0;
				magic_q <= 1'b1;
				pend_q  <= '0;
				pcnt_q  <= '0;
				set_q   <= '0;
				lay_q   <= '0;
			end else begin
				pos_q   <= pos_nxt;
				magic_q <= magic_nxt;
				pend_q  <= pend_nxt;
				pcnt_q  <= pcnt_nxt;
				set_q   <= set_nxt;
				lay_q   <= lay_nxt;
			end
		end
	end

endmodule

// ----- rtl/ard_queue.sv -----
// Short job queue between the front and back parts.
// Depends on ard_pkg for job_t and the queue depth.
`timescale 1ns / 1ps

module ard_queue
	import ard_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	// Payload storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/ard_back.sv -----
// Back part: feeds head job results to the output register one per unstalled cycle.
// Depends on ard_pkg for job_t, result codes and the character map.
`timescale 1ns / 1ps

module ard_back
	import ard_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  job_t        head,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        item_kind,
	output logic [6:0]  identity_char,
	output logic [63:0] config_word,
	output logic [63:0] topology_word,
	output logic [1:0]  verdict,
	output logic        run_end
);

	logic        valid_q;
	logic        kind_q;
	logic [6:0]  char_q;
	logic [63:0] cfg_q;
	logic [63:0] topo_q;
	logic [1:0]  verd_q;
	logic        end_q;
	logic [1:0]  idx_q;

	logic        load, take_head, is_char, is_last;
	logic [1:0]  total;

	assign load      = !valid_q || !result_stall;
	assign take_head = load && !empty;
	assign total     = head.n_chars + {1'b0, head.has_verdict};
	assign is_char   = (idx_q < head.n_chars);
	assign is_last   = ((idx_q + 2'd1) == total);
	assign pop       = take_head && is_last;

	// Result index within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (take_head) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (take_head) begin
			end_q <= is_last;
			if (is_char) begin
				kind_q <= KIND_CHAR;
				char_q <= b64_char(head.char_idx[idx_q[0]]);
				cfg_q  <= '0;
				topo_q <= '0;
				verd_q <= VERDICT_OK;
			end else begin
				kind_q <= KIND_VERDICT;
				char_q <= '0;
				cfg_q  <= head.cfg;
				topo_q <= head.topo;
				verd_q <= head.verdict;
			end
		end
	end

	assign result_valid  = valid_q;
	assign item_kind     = kind_q;
	assign identity_char = char_q;
	assign config_word   = cfg_q;
	assign topology_word = topo_q;
	assign verdict       = verd_q;
	assign run_end       = end_q;

endmodule

// ----- rtl/authority_record_decoder.sv -----
// Top level of the authority record decoder: front, job queue and back.
// Depends on ard_pkg, ard_front, ard_queue and ard_back.
//
//   channel   handshake                    words
//   byte      byte_valid / byte_stall      data_byte, final_byte
//   result    result_valid / result_stall  item_kind, identity_char, config_word,
//                                          topology_word, verdict, run_end
//
// One byte is accepted per cycle while the two-entry job queue has room.
// Each byte yields zero to three result words; the back part sends one word per
// cycle while result_stall is low, so the output port sets the sustained rate.
// A byte's words are registered in a queue slot, then in the output register.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps filling.
`timescale 1ns / 1ps

module authority_record_decoder
	import ard_pkg::*;
#(
	parameter int RECORD_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        item_kind,
	output logic [6:0]  identity_char,
	output logic [63:0] config_word,
	output logic [63:0] topology_word,
	output logic [1:0]  verdict,
	output logic        run_end
);

	logic full, empty, push, pop, take;
	job_t push_job, head;

	assign byte_stall = full;
	assign take       = byte_valid && !full;

	// Front: classification and state tracking.
	ard_front #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.take      (take),
		.push      (push),
		.push_job  (push_job)
	);

	// Queue decoupling the two sides.
	ard_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	// Back: result serialization.
	ard_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.item_kind    (item_kind),
		.identity_char(identity_char),
		.config_word  (config_word),
		.topology_word(topology_word),
		.verdict      (verdict),
		.run_end      (run_end)
	);

endmodule
